>>> design/kcac_pkg.sv
package kcac_pkg;

    // Field widths of the item and of the panel state
    localparam int KEY_W    = 4;
    localparam int SENS_W   = 2;
    localparam int MODE_W   = 3;
    localparam int COUNT_W  = 3;
    localparam int EVENT_W  = 4;
    localparam int DIGIT_W  = 4;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_NO        = 4'd0;
    localparam logic [KEY_W-1:0] KEY_YES       = 4'd1;
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTER      = 3'd0,
        MODE_ASK_ARM    = 3'd1,
        MODE_ASK_CHANGE = 3'd2,
        MODE_NEW_CODE   = 3'd3,
        MODE_ARMED      = 3'd4,
        MODE_TRIGGERED  = 3'd5
    } mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 4'd0,
        EV_DIGIT    = 4'd1,
        EV_CODE_OK  = 4'd2,
        EV_WRONG    = 4'd3,
        EV_ARMED    = 4'd4,
        EV_ALARM    = 4'd5,
        EV_DISARMED = 4'd6,
        EV_UPDATED  = 4'd7,
        EV_STANDBY  = 4'd8
    } event_t;

    // Input beat
    typedef struct packed {
        logic               key_valid;
        logic [KEY_W-1:0]   key_code;
        logic [SENS_W-1:0]  door_sensors;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               siren_active;
        logic [COUNT_W-1:0] digits_entered;
        logic [EVENT_W-1:0] event_res;
    } out_item_t;

    // Scalar panel state carried between the registers and the step logic
    typedef struct packed {
        mode_t              mode;
        logic [COUNT_W-1:0] count;
    } panel_state_t;

endpackage

>>> design/kcac_step.sv
module kcac_step #(
    parameter int CODE_DIGITS = 4
) (
    input  kcac_pkg::in_item_t     item,
    input  kcac_pkg::panel_state_t state_cur,
    input  logic [kcac_pkg::DIGIT_W-1:0] entry_digits [CODE_DIGITS],
    input  logic [kcac_pkg::DIGIT_W-1:0] stored_code  [CODE_DIGITS],
    output kcac_pkg::panel_state_t state_next,
    output logic [kcac_pkg::DIGIT_W-1:0] entry_next  [CODE_DIGITS],
    output logic [kcac_pkg::DIGIT_W-1:0] stored_next [CODE_DIGITS],
    output kcac_pkg::out_item_t    result
);
    import kcac_pkg::*;

    localparam logic [COUNT_W:0] FULL_COUNT = (COUNT_W+1)'(CODE_DIGITS);

    logic                  is_digit;
    logic                  entry_full;
    logic                  code_match;
    logic [COUNT_W:0]      count_inc;
    logic [COUNT_W-1:0]    take_count;
    event_t                take_event;
    event_t                event_res;
    logic [DIGIT_W-1:0]    wr_digits [CODE_DIGITS];

    // Place the key at the current entry position
    always_comb begin
        for (int i = 0; i < CODE_DIGITS; i++) begin
            wr_digits[i] = (state_cur.count == COUNT_W'(i)) ? item.key_code : entry_digits[i];
        end
    end

    // Compare the completed entry against the stored code
    always_comb begin
        code_match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (wr_digits[i] != stored_code[i]) begin
                code_match = 1'b0;
            end
        end
    end

    // Entry buffer edit for one key: digit, star or hash
    always_comb begin
        is_digit   = item.key_code <= KEY_DIGIT_MAX;
        count_inc  = {1'b0, state_cur.count} + (COUNT_W+1)'(1);
        entry_full = is_digit && (count_inc >= FULL_COUNT);
        take_count = state_cur.count;
        take_event = EV_NONE;
        if (item.key_code == KEY_HASH) begin
            if (state_cur.count != '0) begin
                take_count = state_cur.count - COUNT_W'(1);
            end
        end else if (item.key_code == KEY_STAR) begin
            take_count = '0;
        end else if (is_digit) begin
            take_count = count_inc[COUNT_W-1:0];
            take_event = EV_DIGIT;
        end
    end

    // Advance the panel mode
    always_comb begin
        state_next  = state_cur;
        entry_next  = entry_digits;
        stored_next = stored_code;
        event_res   = EV_NONE;
        unique case (state_cur.mode)
            MODE_ASK_ARM: begin
                if (item.key_valid && item.key_code == KEY_YES) begin
                    state_next = '{mode: MODE_ARMED, count: '0};
                    event_res  = EV_ARMED;
                end else if (item.key_valid && item.key_code == KEY_NO) begin
                    state_next = '{mode: MODE_ASK_CHANGE, count: '0};
                end
            end
            MODE_ASK_CHANGE: begin
                if (item.key_valid && item.key_code == KEY_YES) begin
                    state_next = '{mode: MODE_NEW_CODE, count: '0};
                end else if (item.key_valid && item.key_code == KEY_NO) begin
                    state_next = '{mode: MODE_ENTER, count: '0};
                    event_res  = EV_STANDBY;
                end
            end
            MODE_NEW_CODE: begin
                if (item.key_valid) begin
                    state_next.count = take_count;
                    event_res        = take_event;
                    if (is_digit) begin
                        entry_next = wr_digits;
                    end
                    if (entry_full) begin
                        stored_next = wr_digits;
                        state_next  = '{mode: MODE_ENTER, count: '0};
                        event_res   = EV_UPDATED;
                    end
                end
            end
            MODE_ARMED: begin
                if (item.door_sensors != '0) begin
                    state_next = '{mode: MODE_TRIGGERED, count: '0};
                    event_res  = EV_ALARM;
                end
            end
            MODE_TRIGGERED: begin
                if (item.key_valid) begin
                    state_next.count = take_count;
                    event_res        = take_event;
                    if (is_digit) begin
                        entry_next = wr_digits;
                    end
                    if (entry_full) begin
                        state_next.count = '0;
                        if (code_match) begin
                            state_next.mode = MODE_ENTER;
                            event_res       = EV_DISARMED;
                        end else begin
                            event_res = EV_WRONG;
                        end
                    end
                end
            end
            default: begin
                state_next.mode = MODE_ENTER;
                if (item.key_valid) begin
                    state_next.count = take_count;
                    event_res        = take_event;
                    if (is_digit) begin
                        entry_next = wr_digits;
                    end
                    if (entry_full) begin
                        state_next.count = '0;
                        if (code_match) begin
                            state_next.mode = MODE_ASK_ARM;
                            event_res       = EV_CODE_OK;
                        end else begin
                            event_res = EV_WRONG;
                        end
                    end
                end
            end
        endcase
    end

    // Build the result beat from the updated state
    always_comb begin
        result.mode           = state_next.mode;
        result.siren_active   = state_next.mode == MODE_TRIGGERED;
        result.digits_entered = state_next.count;
        result.event_res      = event_res;
    end

endmodule

>>> design/keypad_code_alarm_controller_core.sv
// Keypad code lock and alarm panel controller.
// Input channel (s_valid/s_ready/s_item): one beat per sample, carrying an
// optional decoded key press and the two door sensor levels.
// Result channel (m_valid/m_ready/m_item): exactly one beat per input beat,
// giving the panel mode, siren, digits held and the event of that step.
// Pipeline: input register, then the combinational mode update into the
// result register. An accepted beat passes the input register and then
// the result register before it is offered on the result channel.
// Throughput: one beat per cycle unless m_ready stalls, set by the single
// mode update stage; an empty input register takes a beat while a result waits.
// A stall on m_ready holds the result register, then the input register,
// and only then drops s_ready.
// Reset (aresetn low, synchronous): mode enter code, no digits held,
// stored code 1,2,3,4 (digit i is i+1), both stages empty.
// The entry digit buffer has no reset; only digits written since the last
// clear are ever compared.
module keypad_code_alarm_controller_core #(
    parameter int CODE_DIGITS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kcac_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output kcac_pkg::out_item_t m_item
);
    import kcac_pkg::*;

    logic         stage_valid_reg;
    in_item_t     stage_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    logic         advance;

    panel_state_t state_reg;
    panel_state_t state_next;
    out_item_t    result_next;
    logic [DIGIT_W-1:0] entry_reg   [CODE_DIGITS];
    logic [DIGIT_W-1:0] entry_next  [CODE_DIGITS];
    logic [DIGIT_W-1:0] stored_reg  [CODE_DIGITS];
    logic [DIGIT_W-1:0] stored_next [CODE_DIGITS];

    // Move the staged beat into the result register when it is free
    assign advance = stage_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    kcac_step #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_step (
        .item         (stage_item_reg),
        .state_cur    (state_reg),
        .entry_digits (entry_reg),
        .stored_code  (stored_reg),
        .state_next   (state_next),
        .entry_next   (entry_next),
        .stored_next  (stored_next),
        .result       (result_next)
    );

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_item_reg <= s_item;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    // Panel mode, entry count and stored code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_ENTER, count: '0};
            for (int i = 0; i < CODE_DIGITS; i++) begin
                stored_reg[i] <= DIGIT_W'(i + 1);
            end
        end else if (advance) begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
        end
    end

    // Entry digit buffer, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            entry_reg <= entry_next;
        end
    end

`ifndef SYNTHESIS
    // Siren follows the triggered mode in every result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.siren_active == (m_item.mode == MODE_TRIGGERED)))
        else $error("siren_active disagrees with mode");

    // A full entry is always judged, so fewer than CODE_DIGITS are held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_item.digits_entered} < (COUNT_W+1)'(CODE_DIGITS)))
        else $error("digit count reached code length");

    // Input stalls only when both stages hold beats and the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in the pipeline");

    // An armed event always leaves the panel armed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.event_res == EV_ARMED) |-> (m_item.mode == MODE_ARMED))
        else $error("armed event without armed mode");
`endif

endmodule

>>> sim/keypad_code_alarm_controller_checker.sv
module keypad_code_alarm_controller_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  kcac_pkg::in_item_t  s_item,
    input  logic                m_valid,
    input  logic                m_ready,
    input  kcac_pkg::out_item_t m_item,
    output int                  mismatch_count,
    output int                  pending_results,
    output int                  results_checked
);
    import kcac_pkg::*;

    localparam int DIGITS = 4;

    // Shadow copy of the panel
    mode_t                          panel_mode;
    logic [COUNT_W-1:0]             entry_count;
    logic [DIGITS-1:0][DIGIT_W-1:0] entry_digits;
    logic [DIGITS-1:0][DIGIT_W-1:0] stored_code;
    event_t                         step_event;

    out_item_t expected_panel[$];
    out_item_t want;
    int        mismatches = 0;
    int        checked    = 0;

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("checker: result %0d %s: got %0d, expected %0d", checked, what, got, want_v);
        mismatches++;
    endtask

    // Switch mode and drop whatever the entry buffer holds
    function automatic void enter_mode(input mode_t m);
        panel_mode  = m;
        entry_count = '0;
    endfunction

    // Feed one key to the entry buffer; return 1 once the entry is full
    function automatic bit feed_key(input logic [KEY_W-1:0] key);
        if (key == KEY_HASH) begin
            // delete clamps at an empty entry
            if (entry_count != '0) entry_count--;
            return 1'b0;
        end
        if (key == KEY_STAR) begin
            entry_count = '0;
            return 1'b0;
        end
        if (key > KEY_DIGIT_MAX) return 1'b0;
        if (entry_count < COUNT_W'(DIGITS)) entry_digits[entry_count] = key;
        entry_count++;
        step_event = EV_DIGIT;
        return entry_count >= COUNT_W'(DIGITS);
    endfunction

    function automatic bit entry_is_code();
        bit same = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (entry_digits[i] != stored_code[i]) same = 1'b0;
        end
        return same;
    endfunction

    // Advance the shadow panel by one input beat and form its result
    function automatic out_item_t panel_step(input in_item_t beat_in);
        out_item_t        r;
        logic             kv;
        logic [KEY_W-1:0] key;
        kv         = beat_in.key_valid;
        key        = beat_in.key_code;
        step_event = EV_NONE;
        case (panel_mode)
            MODE_ASK_ARM: begin
                if (kv && key == KEY_YES) begin
                    enter_mode(MODE_ARMED);
                    step_event = EV_ARMED;
                end else if (kv && key == KEY_NO) begin
                    enter_mode(MODE_ASK_CHANGE);
                end
            end
            MODE_ASK_CHANGE: begin
                if (kv && key == KEY_YES) begin
                    enter_mode(MODE_NEW_CODE);
                end else if (kv && key == KEY_NO) begin
                    enter_mode(MODE_ENTER);
                    step_event = EV_STANDBY;
                end
            end
            MODE_NEW_CODE: begin
                if (kv && feed_key(key)) begin
                    stored_code = entry_digits;
                    enter_mode(MODE_ENTER);
                    step_event = EV_UPDATED;
                end
            end
            MODE_ARMED: begin
                // keys are ignored, only the doors count
                if (beat_in.door_sensors != '0) begin
                    enter_mode(MODE_TRIGGERED);
                    step_event = EV_ALARM;
                end
            end
            MODE_TRIGGERED: begin
                if (kv && feed_key(key)) begin
                    if (entry_is_code()) begin
                        enter_mode(MODE_ENTER);
                        step_event = EV_DISARMED;
                    end else begin
                        entry_count = '0;
                        step_event  = EV_WRONG;
                    end
                end
            end
            default: begin
                panel_mode = MODE_ENTER;
                if (kv && feed_key(key)) begin
                    if (entry_is_code()) begin
                        enter_mode(MODE_ASK_ARM);
                        step_event = EV_CODE_OK;
                    end else begin
                        entry_count = '0;
                        step_event  = EV_WRONG;
                    end
                end
            end
        endcase
        r.mode           = panel_mode;
        r.siren_active   = (panel_mode == MODE_TRIGGERED);
        r.digits_entered = entry_count;
        r.event_res      = step_event;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            panel_mode   = MODE_ENTER;
            entry_count  = '0;
            entry_digits = '0;
            for (int i = 0; i < DIGITS; i++) stored_code[i] = DIGIT_W'((i % 9) + 1);
            expected_panel.delete();
        end else begin
            // Compare each result beat with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_panel.size() == 0) begin
                    report_mismatch("arrived with nothing pending, mode", m_item.mode, -1);
                end else begin
                    want = expected_panel.pop_front();
                    if (m_item.mode != want.mode)
                        report_mismatch("mode", m_item.mode, want.mode);
                    if (m_item.siren_active != want.siren_active)
                        report_mismatch("siren_active", m_item.siren_active,
                                        want.siren_active);
                    if (m_item.digits_entered != want.digits_entered)
                        report_mismatch("digits_entered", m_item.digits_entered,
                                        want.digits_entered);
                    if (m_item.event_res != want.event_res)
                        report_mismatch("event_res", m_item.event_res, want.event_res);
                    checked++;
                end
            end
            // Predict the result of each accepted input beat
            if (s_valid && s_ready) expected_panel.push_back(panel_step(s_item));
        end
        mismatch_count  <= mismatches;
        pending_results <= expected_panel.size();
        results_checked <= checked;
    end

endmodule

>>> sim/tb_keypad_code_alarm_controller_core.sv
module tb_keypad_code_alarm_controller_core;
    import kcac_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_BEATS   = 120;

    typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE} phase_e;
    typedef enum int {FILL_ENTRY, FILL_PROMPT, FILL_ARMED} fill_e;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int mismatch_count;
    int pending_results;
    int results_checked;

    phase_e phase        = PH_FREE;
    int     hold_cycles  = 0;
    bit     hold_done    = 1'b0;
    int     quiet_cycles = 0;
    int     beats_sent   = 0;
    int     code_changes = 0;
    int     target;

    // Code the panel is believed to hold, digit 0 first
    logic [3:0][KEY_W-1:0] code_now = {4'd4, 4'd3, 4'd2, 4'd1};

    keypad_code_alarm_controller_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    keypad_code_alarm_controller_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pace the result channel; hold it off once for a long stretch
    always @(posedge aclk) begin : recv_pacing
        int stall_pct;
        if (phase == PH_PRESSURE && !hold_done) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else begin
            case (phase)
                PH_RECV_STALL: stall_pct = 66;
                PH_BOTH:       stall_pct = 28;
                default:       stall_pct = 0;
            endcase
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Give up when no beat moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_item_t beat(input logic kv, input logic [KEY_W-1:0] key,
                                      input logic [SENS_W-1:0] sens);
        in_item_t b;
        b.key_valid    = kv;
        b.key_code     = key;
        b.door_sensors = sens;
        return b;
    endfunction

    // Offer one beat after a random idle gap and hold it until accepted
    task automatic send_beat(input in_item_t it);
        int idle_pct;
        case (phase)
            PH_SEND_IDLE: idle_pct = 66;
            PH_BOTH:      idle_pct = 28;
            default:      idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic press(input logic [KEY_W-1:0] key, input logic [SENS_W-1:0] sens);
        send_beat(beat(1'b1, key, sens));
    endtask

    // Beats that the current mode ignores
    task automatic fill(input int n, input fill_e kind);
        logic              kv;
        logic [KEY_W-1:0]  key;
        logic [SENS_W-1:0] sens;
        for (int i = 0; i < n; i++) begin
            kv   = 1'($urandom_range(1));
            key  = 4'($urandom_range(15));
            sens = 2'($urandom_range(3));
            case (kind)
                FILL_ENTRY:  if (kv) key = 4'($urandom_range(15, 12));
                FILL_PROMPT: if (kv) key = 4'($urandom_range(15, 2));
                default:     sens = '0;
            endcase
            send_beat(beat(kv, key, sens));
        end
    endtask

    // Key a four digit code into an empty entry, with random edits on the way
    task automatic key_in_code(input logic [3:0][KEY_W-1:0] digits);
        int pos;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3)) press(4'($urandom_range(9)), 2'($urandom_range(3)));
            press(KEY_STAR, 2'($urandom_range(3)));
        end
        if ($urandom_range(3) == 0) press(KEY_HASH, 2'($urandom_range(3)));
        pos = $urandom_range(5);
        for (int i = 0; i < 4; i++) begin
            // stray digit, then delete it; never as the fourth digit, which would judge
            if (i == pos && i < 3) begin
                press(4'($urandom_range(9)), 2'($urandom_range(3)));
                press(KEY_HASH, 2'($urandom_range(3)));
            end
            if ($urandom_range(7) == 0) fill(1, FILL_ENTRY);
            press(digits[i], 2'($urandom_range(3)));
        end
    endtask

    function automatic logic [3:0][KEY_W-1:0] wrong_code();
        logic [3:0][KEY_W-1:0] w;
        int idx;
        w   = code_now;
        idx = $urandom_range(3);
        w[idx] = 4'((w[idx] + $urandom_range(9, 1)) % 10);
        return w;
    endfunction

    // Bring the panel back to enter code with the believed code from any mode
    task automatic recover();
        press(KEY_STAR, 2'd0);
        press(KEY_NO, 2'd0);
        press(KEY_NO, 2'd0);
        send_beat(beat(1'b0, 4'($urandom_range(15)), 2'($urandom_range(3, 1))));
        press(KEY_STAR, 2'd0);
        for (int i = 0; i < 4; i++) press(code_now[i], 2'd0);
        press(KEY_NO, 2'd0);
        press(KEY_NO, 2'd0);
    endtask

    // One random scenario, starting and ending in enter code mode
    task automatic run_scenario();
        int                    pick;
        logic [3:0][KEY_W-1:0] new_code;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // arm, trip a door, maybe a wrong code, then disarm
            press(KEY_STAR, 2'($urandom_range(3)));
            key_in_code(code_now);
            fill($urandom_range(2), FILL_PROMPT);
            press(KEY_YES, 2'($urandom_range(3)));
            fill($urandom_range(4), FILL_ARMED);
            send_beat(beat(1'($urandom_range(1)), 4'($urandom_range(15)),
                           2'($urandom_range(3, 1))));
            fill($urandom_range(2), FILL_ENTRY);
            if ($urandom_range(1)) key_in_code(wrong_code());
            key_in_code(code_now);
        end else if (pick < 50) begin
            // decline arming and code change
            press(KEY_STAR, 2'($urandom_range(3)));
            key_in_code(code_now);
            fill($urandom_range(2), FILL_PROMPT);
            press(KEY_NO, 2'($urandom_range(3)));
            fill($urandom_range(2), FILL_PROMPT);
            press(KEY_NO, 2'($urandom_range(3)));
        end else if (pick < 65) begin
            // store a new code
            press(KEY_STAR, 2'($urandom_range(3)));
            key_in_code(code_now);
            fill($urandom_range(2), FILL_PROMPT);
            press(KEY_NO, 2'($urandom_range(3)));
            fill($urandom_range(2), FILL_PROMPT);
            press(KEY_YES, 2'($urandom_range(3)));
            for (int i = 0; i < 4; i++) new_code[i] = 4'($urandom_range(9));
            key_in_code(new_code);
            code_now = new_code;
            code_changes++;
        end else if (pick < 75) begin
            press(KEY_STAR, 2'($urandom_range(3)));
            key_in_code(wrong_code());
        end else if (pick < 90) begin
            // raw noise
            repeat ($urandom_range(10, 3))
                send_beat(beat(1'($urandom_range(1)), 4'($urandom_range(15)),
                               2'($urandom_range(3))));
            recover();
        end else begin
            // cut a well-formed sequence short
            press(KEY_STAR, 2'($urandom_range(3)));
            key_in_code(code_now);
            case ($urandom_range(4))
                0: ;
                1: press(KEY_YES, 2'd0);
                2: begin
                    press(KEY_YES, 2'd0);
                    send_beat(beat(1'b0, 4'($urandom_range(15)), 2'($urandom_range(3, 1))));
                    repeat ($urandom_range(3)) press(4'($urandom_range(9)), 2'($urandom_range(3)));
                end
                3: press(KEY_NO, 2'($urandom_range(3)));
                default: begin
                    press(KEY_NO, 2'($urandom_range(3)));
                    press(KEY_YES, 2'($urandom_range(3)));
                    repeat ($urandom_range(3)) press(4'($urandom_range(9)), 2'($urandom_range(3)));
                end
            endcase
            recover();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: edits and ignored keys in enter code
        press(KEY_HASH, 2'd0);
        press(KEY_STAR, 2'd3);
        press(4'd15, 2'd1);
        send_beat(beat(1'b0, 4'd9, 2'd2));
        press(4'd1, 2'd0);
        press(4'd2, 2'd0);
        press(KEY_DIGIT_MAX, 2'd0);
        press(KEY_HASH, 2'd0);
        press(4'd3, 2'd0);
        press(4'd4, 2'd0);
        // prompts: ignored keys, then no, no
        press(4'd7, 2'd0);
        press(KEY_NO, 2'd0);
        press(4'd12, 2'd3);
        press(KEY_NO, 2'd0);
        // arm, ignore a key, trip, wrong code while sounding, disarm
        for (int i = 0; i < 4; i++) press(code_now[i], 2'd0);
        press(KEY_YES, 2'd0);
        press(4'd5, 2'd0);
        send_beat(beat(1'b0, 4'd0, 2'd3));
        repeat (4) press(KEY_DIGIT_MAX, 2'd1);
        for (int i = 0; i < 4; i++) press(code_now[i], 2'd2);

        // Random scenarios across the pacing phases
        for (int p = 0; p < 5; p++) begin
            phase  <= phase_e'(p);
            target  = beats_sent + PHASE_BEATS;
            while (beats_sent < target) run_scenario();
        end
        s_valid <= 1'b0;

        // Drain and let the pipeline settle
        do @(posedge aclk); while (pending_results != 0);
        repeat (8) @(posedge aclk);

        $display("tb: %0d input beats over five pacing phases and a %0d-cycle hold-off,",
                 beats_sent, HOLD_CYCLES);
        $display("tb: %0d results compared; arm, alarm, disarm, standby, %0d code changes",
                 results_checked, code_changes);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
